### rtl/lkd_pkg.sv
// lkd_pkg: shared constants, beat types and sequencer states for the
// longest k-distinct window block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkd_pkg;

  localparam int VALUE_BITS = 10;
  localparam int MAX_LEN    = 1024;
  localparam int POS_BITS   = $clog2(MAX_LEN + 1);
  localparam int CNT_BITS   = $clog2(MAX_LEN + 1);
  localparam int ADDR_BITS  = $clog2(MAX_LEN);
  localparam int LIM_BITS   = 11;
  localparam int SEG_BITS   = 11;
  localparam int CNT_DEPTH  = 2 ** VALUE_BITS;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } in_t;

  typedef struct packed {
    logic [SEG_BITS-1:0] seg_left;
    logic [SEG_BITS-1:0] seg_right;
    logic                overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_CHECK,
    ST_WIN,
    ST_DEC,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### rtl/lkd_ram.sv
// lkd_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/longest_k_distinct_window_core.sv
// longest_k_distinct_window_core: longest segment with at most max_distinct values,
// built on lkd_pkg and lkd_ram (window fifo and occurrence count table).
// a beat runs ST_INC and ST_CHECK (past a full window it only sets overflow), then
// ST_WIN and ST_DEC per value popped through the shared count-table port; each
// value is popped once. Input stalls until a beat is done. The result registers
// at the end, then the window drains; sync reset, then a table clear stalls input.
`timescale 1ns / 1ps
`default_nettype none

module longest_k_distinct_window_core
  import lkd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_t                     out_data,
  input  wire logic                cfg_wen,
  input  wire logic [LIM_BITS-1:0] cfg_wdata
);

  state_t state, state_next;

  logic [VALUE_BITS-1:0] clr_addr;
  logic [LIM_BITS-1:0]   max_distinct;
  logic [CNT_BITS-1:0]   distinct_now;
  logic [POS_BITS-1:0]   window_start;
  logic [POS_BITS-1:0]   position;
  logic [POS_BITS-1:0]   best_length;
  logic [POS_BITS-1:0]   best_start;
  logic [POS_BITS-1:0]   best_end;
  logic                  overflow_seen;
  logic [VALUE_BITS-1:0] cur_val;
  logic                  cur_last;
  logic [VALUE_BITS-1:0] pop_val;
  logic                  draining;

  logic                  win_we;
  logic [ADDR_BITS-1:0]  win_waddr;
  logic [ADDR_BITS-1:0]  win_raddr;
  logic [VALUE_BITS-1:0] win_rdata;
  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [CNT_BITS-1:0]   cnt_wdata;
  logic [VALUE_BITS-1:0] cnt_raddr;
  logic [CNT_BITS-1:0]   cnt_rdata;

  logic                  in_accept;
  logic                  full;
  logic                  ws_le_pos;
  logic                  pop_needed;
  logic                  slot_free;
  logic [POS_BITS-1:0]   ws_m1;
  logic [POS_BITS-1:0]   cur_len;

  assign in_accept  = in_valid && !in_stall;
  assign full       = position >= POS_BITS'(MAX_LEN);
  assign ws_le_pos  = window_start <= position;
  assign pop_needed = ws_le_pos &&
                      (draining || ({1'b0, distinct_now} > {1'b0, max_distinct}));
  assign slot_free  = !out_valid || !out_stall;
  assign ws_m1      = window_start - POS_BITS'(1);
  assign cur_len    = position - window_start + POS_BITS'(1);

  lkd_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_LEN)
  ) u_window (
    .clk  (clk),
    .we   (win_we),
    .waddr(win_waddr),
    .wdata(in_data.value),
    .raddr(win_raddr),
    .rdata(win_rdata)
  );

  lkd_ram #(
    .WIDTH(CNT_BITS),
    .DEPTH(CNT_DEPTH)
  ) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    win_we     = 1'b0;
    win_waddr  = position[ADDR_BITS-1:0];
    win_raddr  = ws_m1[ADDR_BITS-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = cur_val;
    cnt_wdata  = cnt_rdata + CNT_BITS'(1);
    cnt_raddr  = (state == ST_WIN) ? win_rdata : in_data.value;
    unique case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (full) begin
            state_next = in_data.last ? ST_FINISH : ST_IDLE;
          end else begin
            win_we     = 1'b1;
            state_next = ST_INC;
          end
        end
      end
      ST_INC: begin
        cnt_we     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (pop_needed) begin
          state_next = ST_WIN;
        end else if (draining || !cur_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WIN: begin
        state_next = ST_DEC;
      end
      ST_DEC: begin
        // popped value is always present in the window, so its count is nonzero
        cnt_we     = 1'b1;
        cnt_waddr  = pop_val;
        cnt_wdata  = cnt_rdata - CNT_BITS'(1);
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      max_distinct  <= LIM_BITS'(1);
      distinct_now  <= '0;
      window_start  <= POS_BITS'(1);
      position      <= '0;
      best_length   <= '0;
      best_start    <= '0;
      best_end      <= '0;
      overflow_seen <= 1'b0;
      draining      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_distinct <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + VALUE_BITS'(1);
        end
        ST_IDLE: begin
          if (in_accept) begin
            cur_val  <= in_data.value;
            cur_last <= in_data.last;
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              position <= position + POS_BITS'(1);
            end
          end
        end
        ST_INC: begin
          if (cnt_rdata == '0) begin
            distinct_now <= distinct_now + CNT_BITS'(1);
          end
        end
        ST_CHECK: begin
          if (draining) begin
            if (!ws_le_pos) begin
              // window empty: count table is back to zero, reset the sequence
              distinct_now  <= '0;
              window_start  <= POS_BITS'(1);
              position      <= '0;
              best_length   <= '0;
              best_start    <= '0;
              best_end      <= '0;
              overflow_seen <= 1'b0;
              draining      <= 1'b0;
            end
          end else if (!pop_needed && ws_le_pos && (cur_len > best_length)) begin
            best_length <= cur_len;
            best_start  <= window_start;
            best_end    <= position;
          end
        end
        ST_WIN: begin
          pop_val <= win_rdata;
        end
        ST_DEC: begin
          if (cnt_rdata == CNT_BITS'(1)) begin
            distinct_now <= distinct_now - CNT_BITS'(1);
          end
          window_start <= window_start + POS_BITS'(1);
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_data.seg_left  <= SEG_BITS'(best_start);
            out_data.seg_right <= SEG_BITS'(best_end);
            out_data.overflow  <= overflow_seen;
            out_valid          <= 1'b1;
            draining           <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, window_start} <= ({1'b0, position} + (POS_BITS + 1)'(1))))
    else $error("window start ran past the end of the window");

  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, distinct_now} + {1'b0, window_start}) <=
     ({1'b0, position} + (POS_BITS + 1)'(1))))
    else $error("distinct count exceeds window length");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result beat raised outside the finish step");

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (in_stall || $past(clr_addr) == '1))
    else $error("beat taken during the count table clearing pass");
`endif

endmodule

`default_nettype wire
